// ===== rtl/esfm_pkg.sv =====
package esfm_pkg;

	// History geometry
	localparam int HIST_DEPTH = 64;
	localparam int RISE_LAG   = 30;
	localparam int SLOT_W     = $clog2(HIST_DEPTH);
	localparam int LAG_MOD    = RISE_LAG % HIST_DEPTH;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HIST_DEPTH - 1);
	localparam logic [SLOT_W-1:0] LAG_OFS   = SLOT_W'(LAG_MOD);
	localparam logic [SLOT_W:0]   LAG_BACK  = (SLOT_W+1)'(HIST_DEPTH - LAG_MOD);

	// Drain threshold: per-sample limit times (depth - 1)
	localparam int PROD_W = 10 + SLOT_W;
	localparam int CMP_W  = PROD_W + 1;
	localparam logic [PROD_W-1:0] DRAIN_SPAN = PROD_W'(HIST_DEPTH - 1);

	// Fixed range limits
	localparam logic signed [9:0]  THROTTLE_MAX = 10'sd100;
	localparam logic [11:0]        PRESS_MIN    = 12'd800;
	localparam logic [11:0]        PRESS_MAX    = 12'd1100;
	localparam logic signed [12:0] INTAKE_MIN   = -13'sd400;
	localparam logic signed [12:0] INTAKE_MAX   = 13'sd1200;

	// Register reset values
	localparam logic signed [12:0] MAX_WATER_RST  = 13'sd1000;
	localparam logic [14:0]        MIN_BATT_RST   = 15'd11500;
	localparam logic [12:0]        RISE_LIMIT_RST = 13'd100;
	localparam logic [9:0]         DRAIN_RST      = 10'd10;
	localparam logic [15:0]        PERIOD_RST     = 16'd1000;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_WATER  = 3'd0,
		CFG_MIN_BATT   = 3'd1,
		CFG_RISE_LIMIT = 3'd2,
		CFG_DRAIN      = 3'd3,
		CFG_PERIOD     = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		FAULT_NONE     = 3'd0,
		FAULT_WATER    = 3'd1,
		FAULT_BATTERY  = 3'd2,
		FAULT_KNOCK    = 3'd3,
		FAULT_THROTTLE = 3'd4,
		FAULT_PRESSURE = 3'd5,
		FAULT_INTAKE   = 3'd6
	} fault_t;

	typedef struct packed {
		logic [31:0]        now_ms;
		logic signed [12:0] water_temp;
		logic [14:0]        battery_mv;
		logic               knock;
		logic signed [9:0]  throttle_pct;
		logic [11:0]        pressure;
		logic signed [12:0] intake_temp;
	} sample_t;

	typedef struct packed {
		logic signed [12:0] overheat_limit;
		logic [14:0]        min_battery_mv;
		logic [12:0]        temp_rise_limit;
		logic [9:0]         drain_per_sample_mv;
		logic [15:0]        sample_period_ms;
	} cfg_t;

	typedef struct packed {
		logic signed [12:0] newest_temp;
		logic signed [12:0] lagged_temp;
		logic [14:0]        newest_batt;
		logic [14:0]        oldest_batt;
	} hist_t;

endpackage

// ===== rtl/esfm_sample_if.sv =====
interface esfm_sample_if;
	logic               valid;
	logic               ready;
	logic [31:0]        now_ms;
	logic signed [12:0] water_temp;
	logic [14:0]        battery_mv;
	logic               knock;
	logic signed [9:0]  throttle_pct;
	logic [11:0]        pressure;
	logic signed [12:0] intake_temp;

	modport source (
		output valid, now_ms, water_temp, battery_mv, knock, throttle_pct, pressure,
			intake_temp,
		input  ready
	);
	modport sink (
		input  valid, now_ms, water_temp, battery_mv, knock, throttle_pct, pressure,
			intake_temp,
		output ready
	);
endinterface

// ===== rtl/esfm_result_if.sv =====
interface esfm_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] fault_code;

	modport source (output valid, fault_code, input ready);
	modport sink (input valid, fault_code, output ready);
endinterface

// ===== rtl/esfm_history.sv =====
module esfm_history (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  esfm_pkg::sample_t smp,
	input  logic [15:0]      period,
	output esfm_pkg::hist_t  hist
);
	import esfm_pkg::*;

	logic [SLOT_W-1:0]     slot_q;
	logic [31:0]           last_ms_q;
	logic [HIST_DEPTH-1:0] fill_q;
	logic signed [12:0]    newest_temp_q;
	logic [14:0]           newest_batt_q;

	logic signed [12:0] temp_mem [HIST_DEPTH];
	logic [14:0]        batt_mem [HIST_DEPTH];

	logic signed [12:0] lag_rd_s2;
	logic [14:0]        old_rd_s2;
	logic               lag_vld_s2;
	logic               old_vld_s2;

	logic [31:0]       elapsed;
	logic              upd;
	logic [SLOT_W-1:0] slot_inc;
	logic [SLOT_W-1:0] slot_dec;
	logic [SLOT_W-1:0] newest_idx;
	logic [SLOT_W-1:0] oldest_idx;
	logic [SLOT_W:0]   lag_sum;
	logic [SLOT_W-1:0] lag_idx;

	// Sample timing: update when the elapsed time reaches the period
	assign elapsed = smp.now_ms - last_ms_q;
	assign upd     = (elapsed >= {16'd0, period});

	// Slot arithmetic modulo the history depth
	assign slot_inc   = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
	assign slot_dec   = (slot_q == '0) ? LAST_SLOT : slot_q - 1'b1;
	assign newest_idx = upd ? slot_q : slot_dec;
	assign oldest_idx = upd ? slot_inc : slot_q;
	assign lag_sum    = ({1'b0, newest_idx} >= {1'b0, LAG_OFS})
		? {1'b0, newest_idx} - {1'b0, LAG_OFS}
		: {1'b0, newest_idx} + LAG_BACK;
	assign lag_idx    = lag_sum[SLOT_W-1:0];

	// Control state and newest entry, which stays in flops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q        <= '0;
			last_ms_q     <= '0;
			fill_q        <= '0;
			newest_temp_q <= '0;
			newest_batt_q <= '0;
		end else if (advance && upd) begin
			slot_q          <= slot_inc;
			last_ms_q       <= smp.now_ms;
			fill_q[slot_q]  <= 1'b1;
			newest_temp_q   <= smp.water_temp;
			newest_batt_q   <= smp.battery_mv;
		end
	end

	// Ring writes
	always_ff @(posedge clk) begin
		if (advance && upd) begin
			temp_mem[slot_q] <= smp.water_temp;
			batt_mem[slot_q] <= smp.battery_mv;
		end
	end

	// Registered ring reads at the post-update slots
	always_ff @(posedge clk) begin
		if (advance) begin
			lag_rd_s2 <= temp_mem[lag_idx];
			old_rd_s2 <= batt_mem[oldest_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lag_vld_s2 <= 1'b0;
			old_vld_s2 <= 1'b0;
		end else if (advance) begin
			lag_vld_s2 <= fill_q[lag_idx];
			old_vld_s2 <= fill_q[oldest_idx];
		end
	end

	// Unwritten slots read as zero; a lag of a whole ring lands on the newest
	always_comb begin
		hist.newest_temp = newest_temp_q;
		hist.newest_batt = newest_batt_q;
		hist.oldest_batt = old_vld_s2 ? old_rd_s2 : '0;
		if (LAG_MOD == 0)
			hist.lagged_temp = newest_temp_q;
		else
			hist.lagged_temp = lag_vld_s2 ? lag_rd_s2 : '0;
	end

endmodule

// ===== rtl/esfm_classify.sv =====
module esfm_classify (
	input  esfm_pkg::sample_t smp,
	input  esfm_pkg::cfg_t    cfg,
	input  esfm_pkg::hist_t   hist,
	output esfm_pkg::fault_t  code
);
	import esfm_pkg::*;

	logic signed [13:0]      rise;
	logic signed [13:0]      rise_lim;
	logic signed [15:0]      drop;
	logic signed [CMP_W-1:0] drop_x;
	logic [PROD_W-1:0]       drain_lim;
	logic signed [CMP_W-1:0] drain_x;
	logic                    rise_hit;
	logic                    drain_hit;

	// Trend checks
	assign rise      = 14'(hist.newest_temp) - 14'(hist.lagged_temp);
	assign rise_lim  = $signed({1'b0, cfg.temp_rise_limit});
	assign rise_hit  = (rise > rise_lim);

	assign drop      = $signed({1'b0, hist.oldest_batt}) - $signed({1'b0, hist.newest_batt});
	assign drop_x    = CMP_W'(drop);
	assign drain_lim = PROD_W'(cfg.drain_per_sample_mv) * DRAIN_SPAN;
	assign drain_x   = $signed({1'b0, drain_lim});
	assign drain_hit = (drop_x > drain_x);

	// First fault in priority order
	always_comb begin
		if (smp.water_temp > cfg.overheat_limit)
			code = FAULT_WATER;
		else if (smp.battery_mv < cfg.min_battery_mv)
			code = FAULT_BATTERY;
		else if (smp.knock)
			code = FAULT_KNOCK;
		else if (smp.throttle_pct < 10'sd0 || smp.throttle_pct > THROTTLE_MAX)
			code = FAULT_THROTTLE;
		else if (smp.pressure < PRESS_MIN || smp.pressure > PRESS_MAX)
			code = FAULT_PRESSURE;
		else if (smp.intake_temp < INTAKE_MIN || smp.intake_temp > INTAKE_MAX)
			code = FAULT_INTAKE;
		else if (rise_hit)
			code = FAULT_WATER;
		else if (drain_hit)
			code = FAULT_BATTERY;
		else
			code = FAULT_NONE;
	end

endmodule

// ===== rtl/engine_sensor_fault_monitor_top.sv =====
// Engine sensor fault monitor. Each sample transaction yields one fault_code transaction,
// and a new sample is taken every cycle while the result side is ready. Stage 1 registers
// the sample; at the move to stage 2 the 32-bit elapsed-time compare decides whether water
// temperature and battery voltage enter the two ring histories, and each ring's single read
// port is read at its lag or oldest slot; stage 2 classifies and the result register holds
// the code. The rings read as zero after reset at once through per-slot fill flags, with no
// clearing pass. Configuration writes take effect at the next edge and are meant for idle
// periods.
module engine_sensor_fault_monitor_top (
	input  logic                                clk,
	input  logic                                arst_n,
	esfm_sample_if.sink                         sample,
	esfm_result_if.source                       result,
	input  logic                                cfg_we,
	input  logic [esfm_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [esfm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import esfm_pkg::*;

	cfg_t    cfg_q;
	logic    vld_s1;
	sample_t smp_s1;
	logic    vld_s2;
	sample_t smp_s2;
	logic    vld_s3;
	fault_t  code_s3;

	logic    ld2;
	logic    ld3;
	logic    advance;
	sample_t smp_in;
	hist_t   hist;
	fault_t  code;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.overheat_limit      <= MAX_WATER_RST;
			cfg_q.min_battery_mv      <= MIN_BATT_RST;
			cfg_q.temp_rise_limit     <= RISE_LIMIT_RST;
			cfg_q.drain_per_sample_mv <= DRAIN_RST;
			cfg_q.sample_period_ms    <= PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_MAX_WATER:  cfg_q.overheat_limit      <= $signed(cfg_wdata[12:0]);
				CFG_MIN_BATT:   cfg_q.min_battery_mv      <= cfg_wdata[14:0];
				CFG_RISE_LIMIT: cfg_q.temp_rise_limit     <= cfg_wdata[12:0];
				CFG_DRAIN:      cfg_q.drain_per_sample_mv <= cfg_wdata[9:0];
				CFG_PERIOD:     cfg_q.sample_period_ms    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Pipeline flow control
	assign ld3          = !vld_s3 || result.ready;
	assign ld2          = !vld_s2 || ld3;
	assign advance      = vld_s1 && ld2;
	assign sample.ready = !vld_s1 || ld2;

	assign smp_in.now_ms       = sample.now_ms;
	assign smp_in.water_temp   = sample.water_temp;
	assign smp_in.battery_mv   = sample.battery_mv;
	assign smp_in.knock        = sample.knock;
	assign smp_in.throttle_pct = sample.throttle_pct;
	assign smp_in.pressure     = sample.pressure;
	assign smp_in.intake_temp  = sample.intake_temp;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (sample.ready)
				vld_s1 <= sample.valid;
			if (ld2)
				vld_s2 <= vld_s1;
			if (ld3)
				vld_s3 <= vld_s2;
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid)
			smp_s1 <= smp_in;
		if (advance)
			smp_s2 <= smp_s1;
		if (ld3 && vld_s2)
			code_s3 <= code;
	end

	esfm_history u_history (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.smp     (smp_s1),
		.period  (cfg_q.sample_period_ms),
		.hist    (hist)
	);

	esfm_classify u_classify (
		.smp  (smp_s2),
		.cfg  (cfg_q),
		.hist (hist),
		.code (code)
	);

	assign result.valid      = vld_s3;
	assign result.fault_code = code_s3;

endmodule

// ===== bench/engine_sensor_fault_monitor_top_tb.sv =====
`timescale 1ns / 1ps

module engine_sensor_fault_monitor_top_tb;
	import esfm_pkg::*;

	localparam int NUM_PHASES     = 6;
	localparam int ITEMS_PER_PHASE = 255;
	localparam int NUM_DIRECTED   = 24;
	localparam int DRAIN_CYCLES   = 12;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	typedef struct {
		sample_t smp;
		bit      typed;
		fault_t  want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	esfm_sample_if sample_ch ();
	esfm_result_if result_ch ();

	engine_sensor_fault_monitor_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow of the monitor: thresholds and both ring histories
	cfg_t               mon_cfg;
	logic signed [12:0] temp_hist [HIST_DEPTH];
	logic [14:0]        batt_hist [HIST_DEPTH];
	int                 hist_slot;
	logic [31:0]        hist_last_ms;

	fault_t pending_codes [$];
	int     mismatch_count = 0;
	bit     idle_on = 1'b1;

	// Sensor trajectory for the random part
	logic [31:0] gen_ms;
	int          gen_water;
	int          gen_batt;

	// Directed samples: after reset thresholds are 1000 / 11500 / 100 / 10 / 1000 ms
	dir_row_t dir_rows [NUM_DIRECTED] = '{
		'{'{32'd0,    0,     12000, 1'b0, 50,   1000, 200},   1'b1, FAULT_NONE},
		'{'{32'd500,  1001,  12000, 1'b0, 50,   1000, 200},   1'b1, FAULT_WATER},
		'{'{32'd999,  4095,  0,     1'b0, 50,   1000, 200},   1'b1, FAULT_WATER},
		'{'{32'd1000, -4096, 11499, 1'b0, 50,   1000, 200},   1'b1, FAULT_BATTERY},
		'{'{32'd1001, 0,     0,     1'b0, 50,   1000, 200},   1'b1, FAULT_BATTERY},
		'{'{32'd1200, 0,     12000, 1'b1, 50,   1000, 200},   1'b1, FAULT_KNOCK},
		'{'{32'd1250, 0,     12000, 1'b0, -1,   1000, 200},   1'b1, FAULT_THROTTLE},
		'{'{32'd1300, 0,     12000, 1'b0, 101,  1000, 200},   1'b1, FAULT_THROTTLE},
		'{'{32'd1350, 0,     12000, 1'b0, -512, 1000, 200},   1'b1, FAULT_THROTTLE},
		'{'{32'd1400, 0,     12000, 1'b0, 511,  1000, 200},   1'b1, FAULT_THROTTLE},
		'{'{32'd1450, 0,     12000, 1'b0, 50,   799,  200},   1'b1, FAULT_PRESSURE},
		'{'{32'd1500, 0,     12000, 1'b0, 50,   1101, 200},   1'b1, FAULT_PRESSURE},
		'{'{32'd1550, 0,     12000, 1'b0, 50,   0,    200},   1'b1, FAULT_PRESSURE},
		'{'{32'd1600, 0,     12000, 1'b0, 50,   4095, 200},   1'b1, FAULT_PRESSURE},
		'{'{32'd1650, 0,     12000, 1'b0, 50,   1000, -401},  1'b1, FAULT_INTAKE},
		'{'{32'd1700, 0,     12000, 1'b0, 50,   1000, 1201},  1'b1, FAULT_INTAKE},
		'{'{32'd1750, 0,     12000, 1'b0, 50,   1000, -4096}, 1'b1, FAULT_INTAKE},
		'{'{32'd1800, 0,     12000, 1'b0, 50,   1000, 4095},  1'b1, FAULT_INTAKE},
		// every limit exactly at its edge, still healthy
		'{'{32'd1999, 1000,  11500, 1'b0, 100,  1100, 1200},  1'b1, FAULT_NONE},
		'{'{32'd1999, 0,     32767, 1'b0, 0,    800,  -400},  1'b1, FAULT_NONE},
		// second history entry jumps 100.0 C over a zero lag slot: rapid rise
		'{'{32'd2000, 1000,  12000, 1'b0, 50,   1000, 200},   1'b1, FAULT_WATER},
		// timestamp wrap around 2^32
		'{'{32'hFFFF_FFFF, 0, 12000, 1'b0, 50,  1000, 200},   1'b0, FAULT_NONE},
		'{'{32'h0000_0100, 0, 12000, 1'b0, 50,  1000, 200},   1'b0, FAULT_NONE},
		'{'{32'h0000_0400, 0, 12000, 1'b0, 50,  1000, 200},   1'b0, FAULT_NONE}
	};

	// Per phase: max water, min battery, rise limit, drain per sample, period
	logic [15:0] phase_words [NUM_PHASES][5] = '{
		'{16'd1000,  16'd11500, 16'd100,  16'd10,   16'd1000},
		'{16'd3000,  16'd0,     16'd0,    16'd0,    16'd1},
		'{16'hF830,  16'hFFFF,  16'd5000, 16'd1000, 16'd65535},
		'{16'd1500,  16'd9000,  16'd50,   16'd5,    16'd0},
		'{16'd1200,  16'd10000, 16'd200,  16'd2,    16'd7},
		'{16'd2500,  16'd11000, 16'd300,  16'd8,    16'd50}
	};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Register write as the block sees it: masked, water limit sign-extended
	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] d);
		case (idx)
			CFG_MAX_WATER:  mon_cfg.overheat_limit      = d[12:0];
			CFG_MIN_BATT:   mon_cfg.min_battery_mv      = d[14:0];
			CFG_RISE_LIMIT: mon_cfg.temp_rise_limit     = d[12:0];
			CFG_DRAIN:      mon_cfg.drain_per_sample_mv = d[9:0];
			CFG_PERIOD:     mon_cfg.sample_period_ms    = d[15:0];
			default: ;
		endcase
	endfunction

	// History update, then first fault in priority order
	function automatic fault_t classify_sample(sample_t s);
		logic [31:0] elapsed;
		int newest, lagged, rise, drop;
		fault_t code;
		elapsed = s.now_ms - hist_last_ms;
		if (elapsed >= 32'(mon_cfg.sample_period_ms)) begin
			temp_hist[hist_slot] = s.water_temp;
			batt_hist[hist_slot] = s.battery_mv;
			hist_slot = (hist_slot + 1) % HIST_DEPTH;
			hist_last_ms = s.now_ms;
		end
		newest = (hist_slot + HIST_DEPTH - 1) % HIST_DEPTH;
		lagged = (newest + HIST_DEPTH - RISE_LAG % HIST_DEPTH) % HIST_DEPTH;
		rise = temp_hist[newest] - temp_hist[lagged];
		// oldest entry sits in the slot about to be overwritten
		drop = batt_hist[hist_slot] - batt_hist[newest];
		if (s.water_temp > mon_cfg.overheat_limit)
			code = FAULT_WATER;
		else if (s.battery_mv < mon_cfg.min_battery_mv)
			code = FAULT_BATTERY;
		else if (s.knock)
			code = FAULT_KNOCK;
		else if (s.throttle_pct < 0 || s.throttle_pct > 100)
			code = FAULT_THROTTLE;
		else if (s.pressure < 12'd800 || s.pressure > 12'd1100)
			code = FAULT_PRESSURE;
		else if (s.intake_temp < -400 || s.intake_temp > 1200)
			code = FAULT_INTAKE;
		else if (rise > int'(mon_cfg.temp_rise_limit))
			code = FAULT_WATER;
		else if (drop > int'(mon_cfg.drain_per_sample_mv) * (HIST_DEPTH - 1))
			code = FAULT_BATTERY;
		else
			code = FAULT_NONE;
		return code;
	endfunction

	// Plausible engine trace with a drifting coolant temperature and a sagging
	// battery, plus a share of out-of-range noise
	task automatic make_sample(output sample_t s);
		int pick, per, hi, lo;
		per = mon_cfg.sample_period_ms;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			gen_ms = gen_ms + 32'($urandom_range(per, 2 * per));
		else if (pick < 85)
			gen_ms = gen_ms + 32'($urandom_range(0, per));
		else if (pick >= 95)
			gen_ms = $urandom;

		hi = mon_cfg.overheat_limit;
		if (hi > 3000)
			hi = 3000;
		gen_water = gen_water + int'($urandom_range(0, 50)) - 20;
		if (gen_water > hi)
			gen_water = hi - int'($urandom_range(0, 300));
		if (gen_water < -2000)
			gen_water = -2000;

		lo = mon_cfg.min_battery_mv;
		gen_batt = gen_batt - int'($urandom_range(0, 30)) + 5;
		if (gen_batt < lo)
			gen_batt = 32767 - int'($urandom_range(0, 2000));
		if (gen_batt < lo)
			gen_batt = lo;
		if (gen_batt > 32767)
			gen_batt = 32767;

		s.now_ms       = gen_ms;
		s.water_temp   = 13'(gen_water);
		s.battery_mv   = 15'(gen_batt);
		s.knock        = 1'b0;
		s.throttle_pct = 10'($urandom_range(0, 100));
		s.pressure     = 12'($urandom_range(800, 1100));
		s.intake_temp  = 13'(int'($urandom_range(0, 1600)) - 400);

		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			case ($urandom_range(0, 5))
				0: s.water_temp   = 13'($urandom);
				1: s.battery_mv   = 15'($urandom);
				2: s.knock        = 1'b1;
				3: s.throttle_pct = 10'($urandom);
				4: s.pressure     = 12'($urandom);
				default: s.intake_temp = 13'($urandom);
			endcase
		end else if (pick < 16) begin
			s.water_temp   = 13'($urandom);
			s.battery_mv   = 15'($urandom);
			s.knock        = 1'($urandom);
			s.throttle_pct = 10'($urandom);
			s.pressure     = 12'($urandom);
			s.intake_temp  = 13'($urandom);
		end
	endtask

	task automatic idle_gap();
		int n;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 19);
			sample_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Present one sample and hold it until the transaction completes
	task automatic send_sample(sample_t s, bit typed, fault_t want);
		fault_t code;
		sample_ch.valid        <= 1'b1;
		sample_ch.now_ms       <= s.now_ms;
		sample_ch.water_temp   <= s.water_temp;
		sample_ch.battery_mv   <= s.battery_mv;
		sample_ch.knock        <= s.knock;
		sample_ch.throttle_pct <= s.throttle_pct;
		sample_ch.pressure     <= s.pressure;
		sample_ch.intake_temp  <= s.intake_temp;
		@(posedge clk);
		while (sample_ch.ready !== 1'b1)
			@(posedge clk);
		code = classify_sample(s);
		pending_codes.push_back(typed ? want : code);
	endtask

	// Write all five thresholds of a phase; the block is idle here
	task automatic program_phase(int ph);
		cfg_reg_t r;
		r = r.first();
		do begin
			cfg_we    <= 1'b1;
			cfg_idx   <= r;
			cfg_wdata <= phase_words[ph][int'(r)];
			@(posedge clk);
			apply_reg(r, phase_words[ph][int'(r)]);
			r = r.next();
		end while (r != r.first());
		// an index past the register list must change nothing
		if (ph == 4) begin
			cfg_idx   <= CFG_SPARE;
			cfg_wdata <= 16'hFFFF;
			@(posedge clk);
			apply_reg(CFG_SPARE, 16'hFFFF);
		end
		cfg_we <= 1'b0;
	endtask

	// Result side: random stall bursts while idling is on
	initial begin
		int stall_left;
		stall_left = 0;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Compare each fault_code transaction with the oldest pending code
	always @(posedge clk) begin
		fault_t want;
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (pending_codes.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected fault_code transaction: expected none, got %0d",
					$time, result_ch.fault_code);
			end else begin
				want = pending_codes.pop_front();
				if (result_ch.fault_code !== want) begin
					mismatch_count++;
					$display("%0t: fault_code mismatch: expected %0d (%s), got %0d",
						$time, want, want.name(), result_ch.fault_code);
				end
			end
		end
	end

	// Stimulus
	initial begin
		sample_t s;
		arst_n                 <= 1'b0;
		cfg_we                 <= 1'b0;
		cfg_idx                <= CFG_MAX_WATER;
		cfg_wdata              <= '0;
		sample_ch.valid        <= 1'b0;
		sample_ch.now_ms       <= '0;
		sample_ch.water_temp   <= '0;
		sample_ch.battery_mv   <= '0;
		sample_ch.knock        <= 1'b0;
		sample_ch.throttle_pct <= '0;
		sample_ch.pressure     <= '0;
		sample_ch.intake_temp  <= '0;

		mon_cfg = '{13'sd1000, 15'd11500, 13'd100, 10'd10, 16'd1000};
		foreach (temp_hist[i]) begin
			temp_hist[i] = '0;
			batt_hist[i] = '0;
		end
		hist_slot    = 0;
		hist_last_ms = '0;
		gen_ms       = 32'hFFFF_0000;
		gen_water    = 500;
		gen_batt     = 13000;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			idle_gap();
			send_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			sample_ch.valid <= 1'b0;
			while (pending_codes.size() != 0)
				@(posedge clk);
			program_phase(ph);
			idle_on = (ph != 2 && ph != NUM_PHASES - 1);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				idle_gap();
				make_sample(s);
				send_sample(s, 1'b0, FAULT_NONE);
			end
		end
		sample_ch.valid <= 1'b0;

		while (pending_codes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_codes.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("%0t: timeout, %0d fault codes still pending", $time, pending_codes.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
